/* hw/rtl/smm_pkg.sv */
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants, codes and controller/datapath types for the sorted set
// merge engine.
// ----------------------------------------------------------------------------
package smm_pkg;

   // default queue depth per list
   localparam int QUEUE_DEPTH = 32;

   // element and operation widths
   localparam int VALUE_W = 64;
   localparam int OP_W    = 2;

   // set operation codes
   localparam logic [OP_W-1:0] OP_INTERSECT = 2'd0;
   localparam logic [OP_W-1:0] OP_UNION     = 2'd1;
   localparam logic [OP_W-1:0] OP_DIFF      = 2'd2;

   // one result before the overflow and last flags are attached
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               has_value;
      logic               done_flag;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic do_step;
      logic do_done;
      logic do_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic loop_go;
      logic step_emit;
      logic pend_valid;
      logic out_free;
      logic done_cond;
      logic ovf;
   } status_type;

endpackage

/* hw/rtl/smm_if.sv */
// ----------------------------------------------------------------------------
// smm_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------

// request channel: one list element or end mark
interface smm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        list_sel;
   logic                        has_value;
   logic [smm_pkg::VALUE_W-1:0] value;
   logic                        end_of_list;

   modport source (output valid, output list_sel, output has_value, output value,
                   output end_of_list, input ready);
   modport sink (input valid, input list_sel, input has_value, input value,
                 input end_of_list, output ready);
endinterface

// response channel: one result of the merge
interface smm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [smm_pkg::VALUE_W-1:0] value_res;
   logic                        has_value_res;
   logic                        done_res;
   logic                        overflow;
   logic                        last;

   modport source (output valid, output value_res, output has_value_res,
                   output done_res, output overflow, output last, input ready);
   modport sink (input valid, input value_res, input has_value_res,
                 input done_res, input overflow, input last, output ready);
endinterface

/* hw/rtl/smm_ram.sv */
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
   parameter int WIDTH = smm_pkg::VALUE_W,
   parameter int DEPTH = smm_pkg::QUEUE_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/smm_datapath.sv */
// ----------------------------------------------------------------------------
// smm_datapath
// List queues, head/count pointers, merge compare, pending result and
// response register.
// ----------------------------------------------------------------------------
module smm_datapath #(
   parameter int QUEUE_DEPTH = smm_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  smm_pkg::cmd_type               cmd,
   output smm_pkg::status_type            status,
   input  logic                           csr_wr_en,
   input  logic [smm_pkg::OP_W-1:0]       csr_wr_data,
   input  logic                           req_list_sel,
   input  logic                           req_has_value,
   input  logic [smm_pkg::VALUE_W-1:0]    req_value,
   input  logic                           req_end_of_list,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [smm_pkg::VALUE_W-1:0]    rsp_value_res,
   output logic                           rsp_has_value_res,
   output logic                           rsp_done_res,
   output logic                           rsp_overflow,
   output logic                           rsp_last
);

   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] HEAD_LAST = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [SUM_W-1:0]  SUM_WRAP  = SUM_W'(QUEUE_DEPTH);

   // queue pointers and list state
   logic [CNT_W-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [ADDR_W-1:0] head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic              ended_a_ff, ended_a_in, ended_b_ff, ended_b_in;
   logic [smm_pkg::OP_W-1:0] set_op_ff;
   logic              ovf_ff, ovf_in;

   // pending result and response register
   smm_pkg::result_type pend_ff, pend_in, out_ff, out_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              out_last_ff, out_last_in;

   // queue memory ports
   logic              wr_a_en, wr_b_en;
   logic [ADDR_W-1:0] wr_a_addr, wr_b_addr;
   logic [smm_pkg::VALUE_W-1:0] rd_a, rd_b;

   // merge step decode
   logic keep_a, keep_b, keep_eq;
   logic has_a, has_b;
   logic step_pop_a, step_pop_b, step_emit;
   logic [smm_pkg::VALUE_W-1:0] step_value;
   logic emit;
   smm_pkg::result_type emit_res;

   // slot behind the tail of a circular queue
   function automatic logic [ADDR_W-1:0] tail_slot(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(count);
      if (sum >= SUM_WRAP) begin
         sum = sum - SUM_WRAP;
      end
      return sum[ADDR_W-1:0];
   endfunction

   // head pointer advance with wrap
   function automatic logic [ADDR_W-1:0] head_next(input logic [ADDR_W-1:0] head);
      return (head == HEAD_LAST) ? '0 : head + ADDR_W'(1);
   endfunction

   assign wr_a_addr = tail_slot(head_a_ff, count_a_ff);
   assign wr_b_addr = tail_slot(head_b_ff, count_b_ff);

   smm_ram #(.WIDTH(smm_pkg::VALUE_W), .DEPTH(QUEUE_DEPTH)) u_queue_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_a_addr),
      .wr_data (req_value),
      .rd_addr (head_a_ff),
      .rd_data (rd_a)
   );

   smm_ram #(.WIDTH(smm_pkg::VALUE_W), .DEPTH(QUEUE_DEPTH)) u_queue_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_b_addr),
      .wr_data (req_value),
      .rd_addr (head_b_ff),
      .rd_data (rd_b)
   );

   // which elements the selected operation keeps
   always_comb begin
      keep_a  = 1'b0;
      keep_b  = 1'b0;
      keep_eq = 1'b0;
      case (set_op_ff)
         smm_pkg::OP_UNION: begin
            keep_a  = 1'b1;
            keep_b  = 1'b1;
            keep_eq = 1'b1;
         end
         smm_pkg::OP_DIFF: begin
            keep_a  = 1'b1;
         end
         default: begin
            keep_eq = 1'b1;
         end
      endcase
   end

   // one two-pointer step on the registered queue heads
   always_comb begin
      has_a      = (count_a_ff != '0);
      has_b      = (count_b_ff != '0);
      step_pop_a = 1'b0;
      step_pop_b = 1'b0;
      step_emit  = 1'b0;
      step_value = rd_a;
      if (has_a && has_b) begin
         if (rd_a < rd_b) begin
            step_pop_a = 1'b1;
            step_emit  = keep_a;
         end else if (rd_a > rd_b) begin
            step_pop_b = 1'b1;
            step_emit  = keep_b;
            step_value = rd_b;
         end else begin
            step_pop_a = 1'b1;
            step_pop_b = 1'b1;
            step_emit  = keep_eq;
         end
      end else if (has_a && ended_b_ff) begin
         step_pop_a = 1'b1;
         step_emit  = keep_a;
      end else if (has_b && ended_a_ff) begin
         step_pop_b = 1'b1;
         step_emit  = keep_b;
         step_value = rd_b;
      end
   end

   // status toward the controller
   always_comb begin
      status.loop_go    = (has_a && has_b) || (has_a && ended_b_ff) ||
                          (has_b && ended_a_ff);
      status.step_emit  = step_emit;
      status.pend_valid = pend_valid_ff;
      status.out_free   = !out_valid_ff || rsp_ready;
      status.done_cond  = ended_a_ff && ended_b_ff && !has_a && !has_b;
      status.ovf        = ovf_ff;
   end

   // next-state logic
   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      head_a_in     = head_a_ff;
      head_b_in     = head_b_ff;
      ended_a_in    = ended_a_ff;
      ended_b_in    = ended_b_ff;
      ovf_in        = ovf_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;
      emit          = 1'b0;
      emit_res      = '{value: step_value, has_value: 1'b1, done_flag: 1'b0};

      // accepted request: push element, mark end of list
      if (cmd.take_req) begin
         ovf_in = 1'b0;
         if (!req_list_sel && !ended_a_ff) begin
            if (req_has_value) begin
               if (count_a_ff == CNT_FULL) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_a_en    = 1'b1;
                  count_a_in = count_a_ff + CNT_W'(1);
               end
            end
            if (req_end_of_list) begin
               ended_a_in = 1'b1;
            end
         end else if (req_list_sel && !ended_b_ff) begin
            if (req_has_value) begin
               if (count_b_ff == CNT_FULL) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_b_en    = 1'b1;
                  count_b_in = count_b_ff + CNT_W'(1);
               end
            end
            if (req_end_of_list) begin
               ended_b_in = 1'b1;
            end
         end
      end

      // merge step: pop heads
      if (cmd.do_step) begin
         emit = step_emit;
         if (step_pop_a) begin
            count_a_in = count_a_ff - CNT_W'(1);
            head_a_in  = head_next(head_a_ff);
         end
         if (step_pop_b) begin
            count_b_in = count_b_ff - CNT_W'(1);
            head_b_in  = head_next(head_b_ff);
         end
      end

      // both lists finished: done result and self clear
      if (cmd.do_done) begin
         emit       = 1'b1;
         emit_res   = '{value: '0, has_value: 1'b0, done_flag: 1'b1};
         head_a_in  = '0;
         head_b_in  = '0;
         ended_a_in = 1'b0;
         ended_b_in = 1'b0;
      end

      // response register drains on handshake
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // new result: older pending one moves to the response register
      if (emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_ovf_in   = ovf_ff;
            out_last_in  = 1'b0;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
      end

      // end of request: final result carries last
      if (cmd.do_last) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            out_ovf_in    = ovf_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (ovf_ff) begin
            out_valid_in = 1'b1;
            out_in       = '{value: '0, has_value: 1'b0, done_flag: 1'b0};
            out_ovf_in   = 1'b1;
            out_last_in  = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         head_a_ff     <= '0;
         head_b_ff     <= '0;
         ended_a_ff    <= 1'b0;
         ended_b_ff    <= 1'b0;
         set_op_ff     <= smm_pkg::OP_INTERSECT;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         head_a_ff     <= head_a_in;
         head_b_ff     <= head_b_in;
         ended_a_ff    <= ended_a_in;
         ended_b_ff    <= ended_b_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_wr_en) begin
            set_op_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value_res     = out_ff.value;
   assign rsp_has_value_res = out_ff.has_value;
   assign rsp_done_res      = out_ff.done_flag;
   assign rsp_overflow      = out_ovf_ff;
   assign rsp_last          = out_last_ff;

endmodule

/* hw/rtl/smm_controller.sv */
// ----------------------------------------------------------------------------
// smm_controller
// Sequencer for one request: accept, merge steps, done check, final result.
// ----------------------------------------------------------------------------
module smm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  smm_pkg::status_type status,
   output smm_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_CMP  = 5'b00100,
      S_FIN  = 5'b01000,
      S_LAST = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_READ;
            end
         end
         // queue heads are being read this cycle
         S_READ: begin
            state_in = status.loop_go ? S_CMP : S_FIN;
         end
         // hold the step while an emitted result has nowhere to go
         S_CMP: begin
            if (!(status.step_emit && status.pend_valid && !status.out_free)) begin
               cmd.do_step = 1'b1;
               state_in    = S_READ;
            end
         end
         S_FIN: begin
            if (!status.done_cond) begin
               state_in = S_LAST;
            end else if (!(status.pend_valid && !status.out_free)) begin
               cmd.do_done = 1'b1;
               state_in    = S_LAST;
            end
         end
         S_LAST: begin
            if (!((status.pend_valid || status.ovf) && !status.out_free)) begin
               cmd.do_last = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* hw/rtl/sorted_set_merge_engine.sv */
// ----------------------------------------------------------------------------
// sorted_set_merge_engine
// One request at a time: after accept, each merge step reads the queue heads, then
// compares and pops; a done check and the final result come before the next ready.
// The registered queue RAM read is why the head read is a state of its own. Results
// stall only on response ready.
// Synchronous reset empties both queues, clears list state and sets union off
// (intersection); no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_merge_engine #(
   parameter int QUEUE_DEPTH = smm_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [smm_pkg::OP_W-1:0] csr_wr_data,
   smm_req_if.sink                  req_chan,
   smm_rsp_if.source                rsp_chan
);

   smm_pkg::cmd_type    cmd;
   smm_pkg::status_type status;

   // sequencer
   smm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // queues and merge datapath
   smm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_list_sel      (req_chan.list_sel),
      .req_has_value     (req_chan.has_value),
      .req_value         (req_chan.value),
      .req_end_of_list   (req_chan.end_of_list),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_value_res     (rsp_chan.value_res),
      .rsp_has_value_res (rsp_chan.has_value_res),
      .rsp_done_res      (rsp_chan.done_res),
      .rsp_overflow      (rsp_chan.overflow),
      .rsp_last          (rsp_chan.last)
   );

endmodule

/* hw/rtl/smm_checker.sv */
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks of the sorted set merge engine, bound to the top level.
// ----------------------------------------------------------------------------
module smm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [smm_pkg::VALUE_W-1:0] rsp_value_res,
   input logic                        rsp_has_value_res,
   input logic                        rsp_done_res,
   input logic                        rsp_overflow,
   input logic                        rsp_last
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_res) &&
         $stable(rsp_has_value_res) && $stable(rsp_done_res) &&
         $stable(rsp_overflow) && $stable(rsp_last))
      else $error("response changed while stalled");

   // done result carries no element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_has_value_res && rsp_value_res == '0)
      else $error("done response carries an element");

   // an empty non-done result only reports a dropped element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value_res && !rsp_done_res |-> rsp_overflow && rsp_last)
      else $error("empty response without overflow");

   // no new request while results of the current one are still coming
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before last response");

endmodule

bind sorted_set_merge_engine smm_checker u_smm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_value_res     (rsp_chan.value_res),
   .rsp_has_value_res (rsp_chan.has_value_res),
   .rsp_done_res      (rsp_chan.done_res),
   .rsp_overflow      (rsp_chan.overflow),
   .rsp_last          (rsp_chan.last)
);
